>>> hw/rtl/mspp_pkg.sv
// shared types, constants and helpers for the msp v1 telemetry frame parser
// no dependencies
package mspp_pkg;

  localparam logic [7:0] BYTE_START = 8'h24;
  localparam logic [7:0] BYTE_M     = 8'h4D;
  localparam logic [7:0] BYTE_DIR   = 8'h3C;

  localparam logic [7:0] KIND_STATUS = 8'd101;
  localparam logic [7:0] KIND_GPS    = 8'd106;
  localparam logic [7:0] KIND_ATT    = 8'd108;

  localparam logic [7:0] LEN_STATUS = 8'd10;
  localparam logic [7:0] LEN_GPS    = 8'd16;
  localparam logic [7:0] LEN_ATT    = 8'd6;

  localparam logic [7:0] FIX_3D = 8'd3;

  localparam int CAP_DEPTH = 16;
  localparam int CAP_AW    = $clog2(CAP_DEPTH);

  // 2^19 / 10 rounded up, exact for magnitudes up to 2^15
  localparam logic [16:0] RECIP_TEN = 17'd52429;

  typedef logic [CAP_DEPTH-1:0][7:0] cap_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_M       = 3'd1,
    PH_DIR     = 3'd2,
    PH_SIZE    = 3'd3,
    PH_TYPE    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_GPS     = 3'd1,
    EV_ATT     = 3'd2,
    EV_STATUS  = 3'd3,
    EV_BADSUM  = 3'd4,
    EV_IGNORED = 3'd5
  } ev_t;

  typedef struct packed {
    logic       chk;
    logic       sum_ok;
    logic [7:0] kind;
    logic [7:0] len;
    cap_t       cap;
  } frame_t;

  // signed tenths to whole units, truncated toward zero
  function automatic logic [12:0] tenth13(input logic [15:0] raw);
    logic [15:0] mag;
    logic [32:0] prod;
    logic [12:0] q;
    mag  = raw[15] ? (16'd0 - raw) : raw;
    prod = {17'd0, mag} * {16'd0, RECIP_TEN};
    q    = prod[31:19];
    return raw[15] ? (13'd0 - q) : q;
  endfunction

endpackage

>>> hw/rtl/mspp_if.sv
// valid/ready channel interfaces for the parser's input bytes and results
// no dependencies
interface mspp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mspp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         frame_event;
  logic [7:0]         fix_kind;
  logic [7:0]         sat_count;
  logic signed [31:0] lat_e7;
  logic signed [31:0] lon_e7;
  logic signed [15:0] alt_dm;
  logic signed [15:0] speed_cms;
  logic signed [12:0] heading_deg;
  logic               armed_flag;
  logic               fix_ready;

  modport source (output valid, output frame_event, output fix_kind, output sat_count,
                  output lat_e7, output lon_e7, output alt_dm, output speed_cms,
                  output heading_deg, output armed_flag, output fix_ready, input ready);
  modport sink (input valid, input frame_event, input fix_kind, input sat_count,
                input lat_e7, input lon_e7, input alt_dm, input speed_cms,
                input heading_deg, input armed_flag, input fix_ready, output ready);
endinterface

>>> hw/rtl/msp_v1_telemetry_frame_parser_top.sv
// top level of the msp v1 telemetry frame parser
// depends on mspp_pkg, mspp_if, mspp_framer and mspp_decode
//
// Parses a stream of received serial bytes, one byte per item, into MSP v1
// request frames ('$' 'M' '<', size, type, payload, xor checksum) and keeps
// GPS, attitude and status telemetry from valid frames. Every input byte
// gives exactly one result item carrying the frame event of that byte and the
// telemetry as it stands after it. A byte is registered on entry, framed and
// decoded from that input register, and the result lands in the output
// register; one byte is taken every cycle while the result side keeps up;
// the framer state and telemetry registers advance once per byte and stall
// with the output register when the sink holds off.
module msp_v1_telemetry_frame_parser_top
  import mspp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mspp_in_if.sink           in_ch,
  mspp_out_if.source        out_ch
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  ev_t        ev_r;

  logic   adv;
  logic   step;
  logic   in_acc;
  frame_t frame;
  ev_t    ev;

  logic [15:0]        fix;
  logic signed [31:0] lat, lon;
  logic signed [15:0] alt, spd;
  logic signed [12:0] hdg;
  logic               armed;

  assign adv         = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && adv;
  assign in_ch.ready = !in_valid_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (step) begin
      ev_r <= ev;
    end
  end

  mspp_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_i  (in_byte_r),
    .frame_o (frame)
  );

  mspp_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .frame_i (frame),
    .ev_o    (ev),
    .fix_o   (fix),
    .lat_o   (lat),
    .lon_o   (lon),
    .alt_o   (alt),
    .spd_o   (spd),
    .hdg_o   (hdg),
    .armed_o (armed)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_event = ev_r;
  assign out_ch.fix_kind    = fix[7:0];
  assign out_ch.sat_count   = fix[15:8];
  assign out_ch.lat_e7      = lat;
  assign out_ch.lon_e7      = lon;
  assign out_ch.alt_dm      = alt;
  assign out_ch.speed_cms   = spd;
  assign out_ch.heading_deg = hdg;
  assign out_ch.armed_flag  = armed;
  assign out_ch.fix_ready   = (fix[7:0] >= FIX_3D) && (lat != 32'sd0);

  a_armed_only_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && armed != $past(armed)) |-> (out_valid_r && ev_r == EV_STATUS))
    else $error("armed flag changed without a status frame");

  a_lat_only_on_gps: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && lat != $past(lat)) |-> (out_valid_r && ev_r == EV_GPS))
    else $error("latitude changed without a gps frame");

  a_hdg_only_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && hdg != $past(hdg)) |->
      (out_valid_r && (ev_r == EV_GPS || ev_r == EV_ATT)))
    else $error("heading changed without a gps or attitude frame");

endmodule

>>> hw/rtl/mspp_framer.sv
// frame tracking: header match, length, running xor and payload capture
// depends on mspp_pkg
module mspp_framer
  import mspp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_i,
  output frame_t     frame_o
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] len_r;
  logic [7:0] kind_r;
  logic [7:0] xor_r;
  cap_t       cap_r;

  logic is_start;
  logic cap_we;
  logic chk;

  assign is_start  = (byte_i == BYTE_START);
  assign count_nxt = count_r + 8'd1;

  always_comb begin
    phase_nxt = PH_IDLE;
    if (is_start) begin
      phase_nxt = PH_M;
    end else begin
      case (phase_r)
        PH_M:       phase_nxt = (byte_i == BYTE_M) ? PH_DIR : PH_IDLE;
        PH_DIR:     phase_nxt = (byte_i == BYTE_DIR) ? PH_SIZE : PH_IDLE;
        PH_SIZE:    phase_nxt = PH_TYPE;
        PH_TYPE:    phase_nxt = (len_r == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        PH_PAYLOAD: phase_nxt = (count_nxt == len_r) ? PH_CHECK : PH_PAYLOAD;
        PH_CHECK:   phase_nxt = PH_IDLE;
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    cap_we = 1'b0;
    chk    = 1'b0;
    if (!is_start) begin
      case (phase_r)
        PH_PAYLOAD: cap_we = (count_r[7:CAP_AW] == '0);
        PH_CHECK:   chk    = 1'b1;
        default: begin
          cap_we = 1'b0;
          chk    = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= 8'd0;
      len_r   <= 8'd0;
      kind_r  <= 8'd0;
      xor_r   <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      if (!is_start) begin
        case (phase_r)
          PH_SIZE: begin
            len_r   <= byte_i;
            count_r <= 8'd0;
            xor_r   <= byte_i;
          end
          PH_TYPE: begin
            kind_r <= byte_i;
            xor_r  <= xor_r ^ byte_i;
          end
          PH_PAYLOAD: begin
            count_r <= count_nxt;
            xor_r   <= xor_r ^ byte_i;
          end
          default: begin
            count_r <= count_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && cap_we) begin
      cap_r[count_r[CAP_AW-1:0]] <= byte_i;
    end
  end

  assign frame_o.chk    = chk;
  assign frame_o.sum_ok = (byte_i == xor_r);
  assign frame_o.kind   = kind_r;
  assign frame_o.len    = len_r;
  assign frame_o.cap    = cap_r;

endmodule

>>> hw/rtl/mspp_decode.sv
// frame decode and kept telemetry registers
// depends on mspp_pkg and the frame info from mspp_framer
module mspp_decode
  import mspp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  frame_t             frame_i,
  output ev_t                ev_o,
  output logic [15:0]        fix_o,
  output logic signed [31:0] lat_o,
  output logic signed [31:0] lon_o,
  output logic signed [15:0] alt_o,
  output logic signed [15:0] spd_o,
  output logic signed [12:0] hdg_o,
  output logic               armed_o
);

  logic [15:0] fix_r;
  logic [31:0] lat_r, lon_r;
  logic [15:0] alt_r, spd_r;
  logic [12:0] hdg_r;
  logic        armed_r;
  ev_t         ev;
  cap_t        c;

  assign c = frame_i.cap;

  always_comb begin
    ev = EV_NONE;
    if (frame_i.chk) begin
      if (!frame_i.sum_ok) begin
        ev = EV_BADSUM;
      end else begin
        case (frame_i.kind)
          KIND_GPS:    ev = (frame_i.len < LEN_GPS) ? EV_IGNORED : EV_GPS;
          KIND_ATT:    ev = (frame_i.len < LEN_ATT) ? EV_IGNORED : EV_ATT;
          KIND_STATUS: ev = (frame_i.len < LEN_STATUS) ? EV_IGNORED : EV_STATUS;
          default:     ev = EV_IGNORED;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_r   <= 16'd0;
      lat_r   <= 32'd0;
      lon_r   <= 32'd0;
      alt_r   <= 16'd0;
      spd_r   <= 16'd0;
      hdg_r   <= 13'd0;
      armed_r <= 1'b0;
    end else if (step) begin
      case (ev)
        EV_GPS: begin
          fix_r <= {c[1], c[0]};
          lat_r <= {c[5], c[4], c[3], c[2]};
          lon_r <= {c[9], c[8], c[7], c[6]};
          alt_r <= {c[11], c[10]};
          spd_r <= {c[13], c[12]};
          hdg_r <= tenth13({c[15], c[14]});
        end
        EV_ATT:    hdg_r   <= tenth13({c[5], c[4]});
        EV_STATUS: armed_r <= c[6][0];
        default:   armed_r <= armed_r;
      endcase
    end
  end

  assign ev_o    = ev;
  assign fix_o   = fix_r;
  assign lat_o   = lat_r;
  assign lon_o   = lon_r;
  assign alt_o   = alt_r;
  assign spd_o   = spd_r;
  assign hdg_o   = hdg_r;
  assign armed_o = armed_r;

endmodule
